[sv/csb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the compressed superblock co-allocation tracker.
// No dependencies; every other file imports this package.
package csb_pkg;

   localparam int SIZE_W  = 11;
   localparam int BB_W    = 8;
   localparam int COUNT_W = 3;
   localparam logic [BB_W-1:0] BLOCK_BYTES_RESET = 8'd64;

   typedef enum logic [1:0] {
      KIND_SET     = 2'd0,
      KIND_INV     = 2'd1,
      KIND_INV_ALL = 2'd2,
      KIND_PROBE   = 2'd3
   } kind_type;

   localparam logic [1:0] OW_SAME     = 2'd0;
   localparam logic [1:0] OW_EXPAND   = 2'd1;
   localparam logic [1:0] OW_CONTRACT = 2'd2;

   typedef struct packed {
      kind_type          kind;
      logic [1:0]        way;
      logic [SIZE_W-1:0] size_bits;
   } req_type;

   typedef struct packed {
      logic               can_coallocate;
      logic [1:0]         overwrite_kind;
      logic               all_compressed;
      logic [COUNT_W-1:0] valid_count;
      logic               any_valid;
      logic [SIZE_W-1:0]  worst_size;
   } rsp_type;

   typedef struct packed {
      logic              all_compressed;
      logic              any_valid;
      logic [SIZE_W-1:0] worst_size;
   } summary_type;

   typedef struct packed {
      logic [SIZE_W-1:0] num;
      logic [SIZE_W-1:0] den;
   } frac_type;

endpackage

[sv/csb_ways.sv]
`timescale 1ns / 1ps
// Per-way state of the superblock (valid, size, compressed flag) and its summary.
// Depends on csb_pkg.
module csb_ways #(
   parameter int WAYS = 4,
   localparam int CW = $clog2(WAYS + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        upd,
   input  csb_pkg::req_type            item,
   input  logic [csb_pkg::SIZE_W-1:0]  blk_bits,
   output csb_pkg::summary_type        summ,
   output logic [CW-1:0]               count
);
   import csb_pkg::*;

   logic [WAYS-1:0]   valid_ff;
   logic [WAYS-1:0]   valid_in;
   logic [WAYS-1:0]   comp_ff;
   logic [WAYS-1:0]   comp_in;
   logic [SIZE_W-1:0] size_ff [WAYS];
   logic [SIZE_W-1:0] size_in [WAYS];
   logic [SIZE_W-1:0] capped;
   logic [SIZE_W-1:0] worst;
   logic [CW-1:0]     cnt;
   logic              allc;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         valid_in[w] = valid_ff[w];
         comp_in[w]  = comp_ff[w];
         size_in[w]  = size_ff[w];
         unique case (item.kind)
            KIND_SET: begin
               if (32'(item.way) == w) begin
                  valid_in[w] = 1'b1;
                  size_in[w]  = item.size_bits;
                  comp_in[w]  = (item.size_bits == '0) || (item.size_bits < blk_bits);
               end
            end
            KIND_INV: begin
               if (32'(item.way) == w) begin
                  valid_in[w] = 1'b0;
                  comp_in[w]  = 1'b0;
                  size_in[w]  = '0;
               end
            end
            KIND_INV_ALL: begin
               valid_in[w] = 1'b0;
               comp_in[w]  = 1'b0;
               size_in[w]  = '0;
            end
            KIND_PROBE: begin
            end
         endcase
      end
   end

   always_comb begin
      cnt    = '0;
      worst  = '0;
      allc   = 1'b1;
      capped = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (valid_in[w]) begin
            cnt    = cnt + CW'(1);
            capped = (size_in[w] > blk_bits) ? blk_bits : size_in[w];
            if (capped > worst) begin
               worst = capped;
            end
            if (!comp_in[w]) begin
               allc = 1'b0;
            end
         end
      end
   end

   assign count               = cnt;
   assign summ.all_compressed = allc;
   assign summ.any_valid      = (cnt != '0);
   assign summ.worst_size     = worst;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (upd) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd) begin
         comp_ff <= comp_in;
         size_ff <= size_in;
      end
   end

endmodule

[sv/csb_probe.sv]
`timescale 1ns / 1ps
// Probe evaluation: packing factors as exact fractions, cross-multiplied compares.
// Depends on csb_pkg.
module csb_probe #(
   parameter int WAYS = 4,
   localparam int CW = $clog2(WAYS + 1)
) (
   input  logic [csb_pkg::SIZE_W-1:0]  blk_bits,
   input  logic [csb_pkg::SIZE_W-1:0]  size_bits,
   input  csb_pkg::summary_type        summ,
   input  logic [CW-1:0]               count,
   output logic                        coalloc,
   output logic [1:0]                  okind
);
   import csb_pkg::*;

   localparam int WW = $clog2(WAYS + 1);
   localparam int PW = SIZE_W + WW;
   localparam int NW = $clog2(WAYS + 2);
   localparam int FW = SIZE_W + NW;
   localparam int XW = 2 * SIZE_W;

   function automatic frac_type factor_of(logic [SIZE_W-1:0] s, logic [SIZE_W-1:0] b);
      frac_type      f;
      logic [PW-1:0] scaled;
      scaled = PW'(s) * PW'(WAYS);
      if (s > b) begin
         f.num = SIZE_W'(1);
         f.den = SIZE_W'(1);
      end else if ((s == '0) || (PW'(b) >= scaled)) begin
         f.num = SIZE_W'(WAYS);
         f.den = SIZE_W'(1);
      end else begin
         f.num = b;
         f.den = s;
      end
      return f;
   endfunction

   frac_type      cur;
   frac_type      nf;
   logic [XW-1:0] lhs;
   logic [XW-1:0] rhs;
   logic [NW-1:0] next_cnt;
   logic [FW-1:0] need_cur;
   logic [FW-1:0] need_nf;
   logic          fit_cur;
   logic          fit_nf;
   logic          nf_big;

   always_comb begin
      if (summ.any_valid) begin
         cur = factor_of(summ.worst_size, blk_bits);
      end else begin
         cur.num = SIZE_W'(1);
         cur.den = SIZE_W'(1);
      end
   end

   assign nf  = factor_of(size_bits, blk_bits);
   assign lhs = XW'(nf.num) * XW'(cur.den);
   assign rhs = XW'(cur.num) * XW'(nf.den);

   assign next_cnt = NW'(count) + NW'(1);
   assign need_cur = FW'(next_cnt) * FW'(cur.den);
   assign need_nf  = FW'(next_cnt) * FW'(nf.den);
   assign fit_cur  = (cur.num > cur.den) && (need_cur <= FW'(cur.num));
   assign fit_nf   = (need_nf <= FW'(nf.num));
   assign nf_big   = (nf.num > nf.den);

   always_comb begin
      priority if (lhs < rhs) begin
         okind = OW_EXPAND;
      end else if (lhs > rhs) begin
         okind = OW_CONTRACT;
      end else begin
         okind = OW_SAME;
      end
   end

   always_comb begin
      if (!summ.all_compressed || !nf_big) begin
         coalloc = 1'b0;
      end else if (count == '0) begin
         coalloc = fit_nf;
      end else if (rhs < lhs) begin
         coalloc = fit_cur;
      end else begin
         coalloc = fit_nf;
      end
   end

endmodule

[sv/compressed_superblock_coalloc_top.sv]
`timescale 1ns / 1ps
// Top level of the compressed superblock co-allocation tracker.
// Depends on csb_pkg, csb_ways and csb_probe.
//
// One request word can be taken on every clock and gives exactly one response word.
// The word is registered, the way-state update and the probe evaluation (two 11x11
// cross-multiplications and two count-by-denominator products) run in a single
// stage, and the response is registered: the word moves into the response register
// when it is free or being read, and waits while a stalled response holds it.
// The response register lets a new request be taken while a finished response waits;
// with both registers full and rsp_ready low the input stalls. The block
// size register is written through csr_we/csr_wdata and should only change while
// no request is in flight.
module compressed_superblock_coalloc_top #(
   parameter int WAYS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  csb_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output csb_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [csb_pkg::BB_W-1:0]  csr_wdata
);
   import csb_pkg::*;

   localparam int CW = $clog2(WAYS + 1);

   logic [BB_W-1:0]   bb_ff;
   req_type           in_ff;
   logic              in_vld_ff;
   logic              in_vld_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic              rsp_vld_ff;
   logic              rsp_vld_in;
   logic              advance;
   logic              req_fire;
   logic [SIZE_W-1:0] blk_bits;
   summary_type       summ;
   logic [CW-1:0]     count;
   logic              coalloc;
   logic [1:0]        okind;
   logic              is_probe;

   assign blk_bits  = {bb_ff, 3'b000};
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_fire  = req_valid && req_ready;

   csb_ways #(.WAYS(WAYS)) u_ways (
      .clock    (clock),
      .reset    (reset),
      .upd      (advance),
      .item     (in_ff),
      .blk_bits (blk_bits),
      .summ     (summ),
      .count    (count)
   );

   csb_probe #(.WAYS(WAYS)) u_probe (
      .blk_bits  (blk_bits),
      .size_bits (in_ff.size_bits),
      .summ      (summ),
      .count     (count),
      .coalloc   (coalloc),
      .okind     (okind)
   );

   assign is_probe = (in_ff.kind == KIND_PROBE);

   always_comb begin
      rsp_in.can_coallocate = is_probe && coalloc;
      rsp_in.overwrite_kind = is_probe ? okind : OW_SAME;
      rsp_in.all_compressed = summ.all_compressed;
      rsp_in.valid_count    = COUNT_W'(count);
      rsp_in.any_valid      = summ.any_valid;
      rsp_in.worst_size     = summ.worst_size;
   end

   always_comb begin
      in_vld_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
      rsp_vld_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bb_ff      <= BLOCK_BYTES_RESET;
         in_ff      <= '0;
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            bb_ff <= csr_wdata;
         end
         if (req_fire) begin
            in_ff <= req_data;
         end
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sv/csb_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the co-allocation tracker, bound to the top level.
// Depends on csb_pkg and compressed_superblock_coalloc_top.
module csb_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  csb_pkg::rsp_type          rsp_data
);
   import csb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_count_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.valid_count != '0) |-> rsp_data.any_valid)
      else $error("nonzero valid count without valid way");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.any_valid |->
         rsp_data.all_compressed && (rsp_data.worst_size == '0))
      else $error("empty superblock reports size or uncompressed way");

   a_coalloc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.can_coallocate |-> rsp_data.all_compressed)
      else $error("co-allocation granted with uncompressed way");

endmodule

bind compressed_superblock_coalloc_top csb_checker u_csb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
